// ===== src/mavg_pkg.sv =====
package mavg_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMMEDIATE_MODE = 1'b1;

  // window length after reset
  localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RST = 7'd8;

  // input operations
  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // result status codes
  localparam int STAT_W = 2;
  localparam logic [STAT_W-1:0] STAT_VALID   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_WARMUP  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RESTART = 2'd2;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/moving_average_window_core.sv =====
// Boxcar moving average. Each add word stores its sample in a ring of up to
// WINDOW_MAX entries and updates a running sum; once the window is full the
// oldest sample is dropped. The average is the sum divided by the window
// length (or by the count so far in immediate mode), truncated toward zero.
// Restart words, and any configuration write, clear the fill state. A restart
// word goes from idle to the done state; an add word that only warms up passes
// through the update state on the way; an add word that produces an average
// also passes through the divide state, where the bit-serial divider retires
// one quotient bit per cycle. The done state hands the result on once the output
// register is free. One word is in work at a time; a finished result waits in
// the output register while the next word is taken in.
module moving_average_window_core import mavg_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic [STAT_W-1:0]             out_status,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int POS_W = $clog2(WINDOW_MAX);
  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CFG_DATA_W-1:0]   wl_r, wl_nxt;
  logic                    imm_r, imm_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [POS_W-1:0]        wpos_r, wpos_nxt;
  logic                    filled_r, filled_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [SAMPLE_BITS-1:0]  sample_r, sample_nxt;
  logic                    neg_r, neg_nxt;
  logic [SAMPLE_BITS-1:0]  res_avg_r, res_avg_nxt;
  logic [STAT_W-1:0]       res_stat_r, res_stat_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]  out_average_r, out_average_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [SAMPLE_BITS-1:0]  rd_r;

  logic [SAMPLE_BITS-1:0]  mem [WINDOW_MAX];

  logic [LEN_W-1:0]        eff_len;
  logic [POS_W-1:0]        pos_fix;
  logic [LEN_W-1:0]        pos1;
  logic signed [SUM_W-1:0] new_ext;
  logic signed [SUM_W-1:0] old_ext;
  logic signed [SUM_W-1:0] sum_upd;
  logic [SUM_W-1:0]        div_dividend;
  logic [LEN_W-1:0]        div_divisor;
  logic [SUM_W-1:0]        div_quo;
  logic [SUM_W-1:0]        avg_full;
  logic                    div_start;
  logic                    mem_we;
  div_stat_t               div_st;

  // window length clamped to 1..WINDOW_MAX
  always_comb begin
    if (wl_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(wl_r) > WINDOW_MAX) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = LEN_W'(wl_r);
    end
  end

  // write position, wrapped if the window shrank under it
  assign pos_fix = (32'(wpos_r) >= 32'(eff_len)) ? '0 : wpos_r;

  // sum update operands
  assign new_ext = SUM_W'($signed(sample_r));
  assign old_ext = SUM_W'($signed(rd_r));
  assign sum_upd = filled_r ? (sum_r - old_ext + new_ext) : (sum_r + new_ext);
  assign pos1    = LEN_W'(pos_r) + LEN_W'(1);

  // divider works on the magnitude, sign restored afterwards
  assign div_dividend = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
  assign avg_full     = neg_r ? (SUM_W'(0) - div_quo) : div_quo;

  // sequencer and state update
  always_comb begin
    state_nxt       = state_r;
    wl_nxt          = wl_r;
    imm_nxt         = imm_r;
    sum_nxt         = sum_r;
    wpos_nxt        = wpos_r;
    filled_nxt      = filled_r;
    pos_nxt         = pos_r;
    sample_nxt      = sample_r;
    neg_nxt         = neg_r;
    res_avg_nxt     = res_avg_r;
    res_stat_nxt    = res_stat_r;
    out_valid_nxt   = out_valid_r;
    out_average_nxt = out_average_r;
    out_status_nxt  = out_status_r;
    div_start       = 1'b0;
    div_divisor     = eff_len;
    mem_we          = 1'b0;

    // register writes restart the window
    if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: begin
          wl_nxt     = cfg_wdata;
          sum_nxt    = '0;
          wpos_nxt   = '0;
          filled_nxt = 1'b0;
        end
        REG_IMMEDIATE_MODE: begin
          imm_nxt    = cfg_wdata[0];
          sum_nxt    = '0;
          wpos_nxt   = '0;
          filled_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_RESTART) begin
            sum_nxt      = '0;
            wpos_nxt     = '0;
            filled_nxt   = 1'b0;
            res_avg_nxt  = '0;
            res_stat_nxt = STAT_RESTART;
            state_nxt    = S_DONE;
          end else begin
            sample_nxt = in_sample;
            pos_nxt    = pos_fix;
            state_nxt  = S_UPD;
          end
        end
      end
      S_UPD: begin
        mem_we  = 1'b1;
        sum_nxt = sum_upd;
        if (!filled_r && (pos1 < eff_len) && !imm_r) begin
          // still filling, no average shown
          wpos_nxt     = POS_W'(pos1);
          res_avg_nxt  = '0;
          res_stat_nxt = STAT_WARMUP;
          state_nxt    = S_DONE;
        end else begin
          if (!filled_r && (pos1 < eff_len)) begin
            div_divisor = pos1;
          end
          if (!filled_r && (pos1 >= eff_len)) begin
            filled_nxt = 1'b1;
          end
          wpos_nxt  = (pos1 >= eff_len) ? '0 : POS_W'(pos1);
          neg_nxt   = sum_upd[SUM_W-1];
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          res_avg_nxt  = avg_full[SAMPLE_BITS-1:0];
          res_stat_nxt = STAT_VALID;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_average_nxt = res_avg_r;
          out_status_nxt  = res_stat_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= WINDOW_LENGTH_RST;
      imm_r       <= 1'b0;
      sum_r       <= '0;
      wpos_r      <= '0;
      filled_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      imm_r       <= imm_nxt;
      sum_r       <= sum_nxt;
      wpos_r      <= wpos_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    sample_r      <= sample_nxt;
    neg_r         <= neg_nxt;
    res_avg_r     <= res_avg_nxt;
    res_stat_r    <= res_stat_nxt;
    out_average_r <= out_average_nxt;
    out_status_r  <= out_status_nxt;
  end

  // sample ring: read the oldest entry while idle, overwrite it on update
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos_r] <= sample_r;
    end
    if (state_r == S_IDLE) begin
      rd_r <= mem[pos_fix];
    end
  end

  // serial divider
  mavg_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (LEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quotient(div_quo),
    .stat    (div_st)
  );

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;
  assign out_status  = out_status_r;

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_wpos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (32'(wpos_r) < 32'(eff_len)))
    else $error("write position outside the window");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown without a finished word");

  a_div_idle_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_st.busy)
    else $error("divider still running while idle");
`endif

endmodule

// ===== src/mavg_div.sv =====
module mavg_div import mavg_pkg::*; #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output div_stat_t             stat
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // one restoring step: bring down the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? DIVISOR_W'(trial - {1'b0, dvs_r}) : DIVISOR_W'(trial);
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef SYNTH
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("divider busy and done together");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r))
    else $error("divider done without a running division");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider running with empty step count");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import mavg_pkg::*;

  localparam int SMP_W       = 16;
  localparam int WIN_MAX     = 64;
  localparam int RAND_WORDS  = 600;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_TYPED} row_kind_t;
  typedef enum logic [1:0] {SMP_RANDOM, SMP_POS_MAX, SMP_NEG_MAX} smp_mode_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] avg;
    logic [STAT_W-1:0]       stat;
  } avg_result_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic                    op;
    logic signed [SMP_W-1:0] smp;
    logic signed [SMP_W-1:0] avg;
    logic [STAT_W-1:0]       stat;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_op = OP_ADD;
  logic signed [SMP_W-1:0] in_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SMP_W-1:0] out_average;
  logic [STAT_W-1:0]       out_status;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  // typed expectation travelling with the word on the input port
  bit          word_typed = 1'b0;
  avg_result_t word_typed_res = '0;

  // window predictor state, matches the block after reset
  logic signed [SMP_W-1:0] win_store [WIN_MAX];
  logic signed [21:0]      win_sum = '0;
  logic [5:0]              win_pos = '0;
  bit                      win_full = 1'b0;
  logic [CFG_DATA_W-1:0]   cfg_len = WINDOW_LENGTH_RST;
  bit                      cfg_imm = 1'b0;

  avg_result_t avg_due_q [$];
  avg_result_t predicted;
  avg_result_t due;
  int          words_sent = 0;
  int          results_seen = 0;
  int          fail_count = 0;
  int          cycles = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  // directed words: extremes, both ops, length clamping, partial averages, wrap
  dir_row_t dir_rows [33] = '{
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sh7FFF, 16'sd0, STAT_WARMUP},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sh8000, 16'sd0, STAT_WARMUP},
    '{ROW_TYPED, '0, '0, OP_RESTART, 16'sh1234, 16'sd0, STAT_RESTART},
    '{ROW_WORD, '0, '0, OP_ADD, 16'shFFFF, '0, '0},
    '{ROW_CFG, REG_WINDOW_LENGTH, 7'd1, OP_ADD, '0, '0, '0},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sh7FFF, 16'sh7FFF, STAT_VALID},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sh8000, 16'sh8000, STAT_VALID},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'shFFFF, 16'shFFFF, STAT_VALID},
    '{ROW_CFG, REG_WINDOW_LENGTH, 7'd0, OP_ADD, '0, '0, '0},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sd12345, 16'sd12345, STAT_VALID},
    '{ROW_CFG, REG_WINDOW_LENGTH, 7'd127, OP_ADD, '0, '0, '0},
    '{ROW_CFG, REG_IMMEDIATE_MODE, 7'd1, OP_ADD, '0, '0, '0},
    '{ROW_TYPED, '0, '0, OP_ADD, -16'sd3, -16'sd3, STAT_VALID},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sd2, 16'sd0, STAT_VALID},
    '{ROW_WORD, '0, '0, OP_ADD, 16'sh8000, '0, '0},
    '{ROW_WORD, '0, '0, OP_RESTART, 16'sd0, '0, '0},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sd5, 16'sd5, STAT_VALID},
    '{ROW_CFG, REG_WINDOW_LENGTH, 7'd2, OP_ADD, '0, '0, '0},
    '{ROW_CFG, REG_IMMEDIATE_MODE, 7'd0, OP_ADD, '0, '0, '0},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sh7FFF, 16'sd0, STAT_WARMUP},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sh7FFF, 16'sh7FFF, STAT_VALID},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sh8000, 16'sd0, STAT_VALID},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sh8000, 16'sh8000, STAT_VALID},
    '{ROW_WORD, '0, '0, OP_ADD, -16'sd7, '0, '0},
    '{ROW_WORD, '0, '0, OP_ADD, 16'sh5555, '0, '0},
    '{ROW_WORD, '0, '0, OP_ADD, 16'shAAAA, '0, '0},
    '{ROW_TYPED, '0, '0, OP_RESTART, 16'sd0, 16'sd0, STAT_RESTART},
    '{ROW_TYPED, '0, '0, OP_ADD, 16'sd9, 16'sd0, STAT_WARMUP},
    '{ROW_CFG, REG_WINDOW_LENGTH, 7'd3, OP_ADD, '0, '0, '0},
    '{ROW_CFG, REG_IMMEDIATE_MODE, 7'd1, OP_ADD, '0, '0, '0},
    '{ROW_WORD, '0, '0, OP_ADD, -16'sd10, '0, '0},
    '{ROW_WORD, '0, '0, OP_ADD, 16'sd3, '0, '0},
    '{ROW_WORD, '0, '0, OP_ADD, 16'sd1, '0, '0}
  };

  moving_average_window_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_average (out_average),
    .out_status  (out_status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #10 clk = ~clk;

  // window length as the block uses it: zero means one, clamp at the store depth
  function automatic logic [6:0] window_span();
    if (cfg_len == 7'd0) return 7'd1;
    if (cfg_len > 7'(WIN_MAX)) return 7'(WIN_MAX);
    return cfg_len;
  endfunction

  function automatic void clear_window();
    win_sum  = '0;
    win_pos  = '0;
    win_full = 1'b0;
  endfunction

  // advance the window by one word and work out its result
  function automatic avg_result_t predict_avg(input logic op,
                                              input logic signed [SMP_W-1:0] smp);
    avg_result_t res;
    logic [6:0]  span;
    logic [6:0]  slot;
    logic [6:0]  divisor;
    longint      quot;
    res  = '0;
    span = window_span();
    if (op == OP_RESTART) begin
      clear_window();
      res.stat = STAT_RESTART;
      return res;
    end
    if (7'(win_pos) >= span) win_pos = '0;
    slot    = 7'(win_pos);
    divisor = span;
    if (!win_full) begin
      win_store[slot[5:0]] = smp;
      win_sum = win_sum + smp;
      slot++;
      if (slot >= span) begin
        win_full = 1'b1;
      end else if (cfg_imm) begin
        divisor = slot;
      end else begin
        win_pos  = slot[5:0];
        res.stat = STAT_WARMUP;
        return res;
      end
    end else begin
      // full window: drop the oldest sample
      win_sum = win_sum - win_store[slot[5:0]] + smp;
      win_store[slot[5:0]] = smp;
      slot++;
    end
    if (slot >= span) slot = '0;
    win_pos  = slot[5:0];
    quot     = longint'(win_sum) / longint'(divisor);
    res.avg  = quot[SMP_W-1:0];
    res.stat = STAT_VALID;
    return res;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic op, input logic signed [SMP_W-1:0] smp,
                           input bit typed, input avg_result_t typed_res);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_sample      <= smp;
    word_typed     <= typed;
    word_typed_res <= typed_res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // register write once every word in flight has returned
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_seen != words_sent) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) cfg_len = data;
    else cfg_imm = data[0];
    clear_window();
  endtask

  // input side: predict each accepted word
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predicted = predict_avg(in_op, in_sample);
      avg_due_q.push_back(word_typed ? word_typed_res : predicted);
    end
  end

  // result side: compare with the oldest pending result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (avg_due_q.size() == 0) begin
        $error("unexpected result word: average %0d, status %0d", out_average, out_status);
        fail_count++;
      end else begin
        due = avg_due_q.pop_front();
        if (out_average !== due.avg) begin
          $error("average: expected %0d, actual %0d", due.avg, out_average);
          fail_count++;
        end
        if (out_status !== due.stat) begin
          $error("status: expected %0d, actual %0d", due.stat, out_status);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("moving_average_window_core regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, calm stretches, one long hold-off to back up the input
  initial begin
    int stall;
    int rx_turn;
    rx_turn = 0;
    forever begin
      @(posedge clk);
      rx_turn++;
      if (rx_turn % 500 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = pick_gap(rx_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // sender: directed words, then random rounds of settings and words
  initial begin
    int                      words_rand;
    int                      round;
    int                      n_words;
    int                      which;
    int                      r;
    logic [CFG_DATA_W-1:0]   len_pick;
    bit                      imm_pick;
    smp_mode_t               mode;
    logic                    op_pick;
    logic signed [SMP_W-1:0] smp_pick;
    words_rand = 0;
    round      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_word(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].kind == ROW_TYPED,
                  {dir_rows[i].avg, dir_rows[i].stat});
      end
    end

    while (words_rand < RAND_WORDS) begin
      // first two rounds drive the sum to both extremes over the widest window
      if (round == 0) begin
        len_pick = 7'd64;
        imm_pick = 1'b0;
        mode     = SMP_POS_MAX;
        which    = 2;
      end else if (round == 1) begin
        len_pick = 7'd127;
        imm_pick = 1'b1;
        mode     = SMP_NEG_MAX;
        which    = 2;
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) len_pick = 7'd0;
        else if (r == 1) len_pick = 7'($urandom_range(65, 127));
        else if (r <= 3) len_pick = 7'($urandom_range(60, 64));
        else len_pick = 7'($urandom_range(1, 12));
        imm_pick = 1'($urandom_range(0, 1));
        mode     = SMP_RANDOM;
        which    = $urandom_range(0, 2);
      end
      if (which != 1) write_reg(REG_WINDOW_LENGTH, len_pick);
      if (which != 0) write_reg(REG_IMMEDIATE_MODE, CFG_DATA_W'(imm_pick));
      tx_calm = ($urandom_range(0, 4) == 0);

      if (mode != SMP_RANDOM) n_words = WIN_MAX + 20;
      else if ($urandom_range(0, 4) == 0) n_words = $urandom_range(1, 8);
      else n_words = int'(window_span()) + $urandom_range(4, 40);

      for (int k = 0; k < n_words; k++) begin
        op_pick = (mode == SMP_RANDOM && $urandom_range(0, 29) == 0) ? OP_RESTART : OP_ADD;
        case (mode)
          SMP_POS_MAX: smp_pick = 16'sh7FFF;
          SMP_NEG_MAX: smp_pick = 16'sh8000;
          default: begin
            r = $urandom_range(0, 15);
            if (r == 0) smp_pick = 16'sh7FFF;
            else if (r == 1) smp_pick = 16'sh8000;
            else smp_pick = SMP_W'($urandom);
          end
        endcase
        send_word(op_pick, smp_pick, 1'b0, '0);
        words_rand++;
        if (words_rand == HOLD_AT) hold_req = 1'b1;
      end
      round++;
    end

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_seen != words_sent) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("moving_average_window_core regression: pass");
    end else begin
      $display("moving_average_window_core regression: fail");
    end
    $finish;
  end

endmodule
